// File: hw/rtl/multi_pattern_byte_matcher_top_assert.svh
// Assertion macros shared by the checker of the byte matcher.
`ifndef MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPBM_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPBM_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mpbm_pkg.sv
// Shared constants and types of the multi-pattern byte matcher.
package mpbm_pkg;

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_SCAN     = 2'd1;
	localparam logic [1:0] CMD_NEW_SCAN = 2'd2;

	localparam logic       REG_MAX_FINDINGS = 1'b0;
	localparam logic [15:0] MAX_FINDINGS_RST = 16'hFFFF;

	// Most findings one image byte may produce.
	localparam int RESULT_CAP = 16;

	// Pending pattern load, broadcast to every slot.
	typedef struct packed {
		logic       busy;
		logic [3:0] slot;
		logic [8:0] len;
		logic [5:0] idx;
		logic [7:0] value;
		logic [2:0] kw;
		logic       enc;
	} ld_req_t;

endpackage

// File: hw/rtl/mpbm_cell.sv
// One history cell: holds a byte of the window, passes it on, compares it to every slot.
module mpbm_cell import mpbm_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic [7:0]            byte_in,
	output logic [7:0]            byte_out,
	input  logic [SLOTS-1:0][7:0] pat,
	output logic [SLOTS-1:0]      eq
);

	logic [7:0] hist_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			hist_q <= byte_in;
		end
	end

	assign byte_out = hist_q;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			eq[s] = (pat[s] == hist_q);
		end
	end

endmodule

// File: hw/rtl/mpbm_slot.sv
// One pattern slot: age-aligned pattern bytes, length, tags and the no-overlap bound.
module mpbm_slot import mpbm_pkg::*; #(
	parameter int SLOT_ID           = 0,
	parameter int MAX_PATTERN_BYTES = 64,
	parameter int OFFSET_BITS       = 48,
	localparam int LW = $clog2(MAX_PATTERN_BYTES + 1),
	localparam int AW = $clog2(MAX_PATTERN_BYTES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ld_req_t                           ld,
	input  logic [MAX_PATTERN_BYTES-1:0]      eq,
	input  logic                              eval,
	input  logic                              clear,
	input  logic [OFFSET_BITS-1:0]            end_ofs,
	output logic                              hit,
	output logic                              ld_done,
	output logic [MAX_PATTERN_BYTES-1:0][7:0] pat,
	output logic [LW-1:0]                     len,
	output logic [2:0]                        kw,
	output logic                              enc
);

	// pat_q[a] holds the pattern byte that must equal the byte of age a.
	logic [7:0]             pat_q [MAX_PATTERN_BYTES];
	logic [LW-1:0]          len_q;
	logic [2:0]             kw_q;
	logic                   enc_q;
	logic [OFFSET_BITS-1:0] ens_q;
	logic                   sel;
	logic [LW-1:0]          tgt;
	logic [LW:0]            wsum;
	logic [AW-1:0]          wpos;
	logic                   idx_ok;
	logic [OFFSET_BITS-1:0] len_ext;
	logic                   cmp_ok;

	assign sel     = ld.busy && (int'(ld.slot) == SLOT_ID);
	assign tgt     = LW'(ld.len);
	assign idx_ok  = int'(ld.idx) < MAX_PATTERN_BYTES;
	assign ld_done = sel && (len_q == tgt);

	always_comb begin
		wsum = (LW+1)'(len_q) + (LW+1)'(MAX_PATTERN_BYTES - 1) - (LW+1)'(ld.idx);
		if (wsum >= (LW+1)'(MAX_PATTERN_BYTES)) begin
			wsum = wsum - (LW+1)'(MAX_PATTERN_BYTES);
		end
		wpos = AW'(wsum);
	end

	// A length change rotates the aligned bytes one place a cycle, so no byte is lost.
	always_ff @(posedge clk) begin
		if (sel) begin
			if (len_q < tgt) begin
				for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
					pat_q[a] <= pat_q[(a + MAX_PATTERN_BYTES - 1) % MAX_PATTERN_BYTES];
				end
			end else if (len_q > tgt) begin
				for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
					pat_q[a] <= pat_q[(a + 1) % MAX_PATTERN_BYTES];
				end
			end else if (idx_ok) begin
				pat_q[wpos] <= ld.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			kw_q  <= '0;
			enc_q <= 1'b0;
			ens_q <= '0;
		end else begin
			if (clear) begin
				ens_q <= '0;
			end else if (eval && hit) begin
				ens_q <= end_ofs;
			end
			if (sel) begin
				if (len_q < tgt) begin
					len_q <= len_q + LW'(1);
				end else if (len_q > tgt) begin
					len_q <= len_q - LW'(1);
				end else begin
					kw_q  <= ld.kw;
					enc_q <= ld.enc;
				end
			end
		end
	end

	assign len_ext = OFFSET_BITS'(len_q);

	always_comb begin
		cmp_ok = 1'b1;
		for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
			if ((a < int'(len_q)) && !eq[a]) begin
				cmp_ok = 1'b0;
			end
		end
	end

	assign hit = (len_q != '0) && (end_ofs >= len_ext) && ((end_ofs - len_ext) >= ens_q)
		&& cmp_ok;

	always_comb begin
		for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
			pat[a] = pat_q[a];
		end
	end

	assign len = len_q;
	assign kw  = kw_q;
	assign enc = enc_q;

endmodule

// File: hw/rtl/multi_pattern_byte_matcher_top.sv
// A finding passes the evaluate flag and then the output register after its image byte is accepted.
// Throughput: one item per cycle while nothing stalls; a byte with more than one finding stalls the input
// while the single output register drains the hit mask in slot order.
// A load stalls the input until the slot has rotated its bytes to the new length and taken the byte.
// Reset clears lengths, tags, counters and bounds at once; there is no clearing pass.
module multi_pattern_byte_matcher_top import mpbm_pkg::*; #(
	parameter int PATTERN_SLOTS     = 16,
	parameter int MAX_PATTERN_BYTES = 64,
	parameter int OFFSET_BITS       = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  pattern_slot,
	input  logic [5:0]  byte_index,
	input  logic [7:0]  byte_value,
	input  logic [6:0]  pattern_length,
	input  logic [2:0]  keyword_id,
	input  logic        encoding,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  match_slot,
	output logic [2:0]  match_keyword,
	output logic        match_encoding,
	output logic [47:0] start_offset,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int M  = MAX_PATTERN_BYTES;
	localparam int PS = PATTERN_SLOTS;
	localparam int OB = OFFSET_BITS;
	localparam int LW = $clog2(M + 1);
	localparam int SW = (PS > 1) ? $clog2(PS) : 1;

	logic [15:0]  max_q;
	ld_req_t      ld_q;
	logic         ev_s1;
	logic [OB-1:0] bytes_seen_q;
	logic [15:0]  findings_q;
	logic [PS-1:0] rem_q;
	logic [OB-1:0] end_q;
	logic [4:0]   n_q;

	logic in_acc, scan_acc, new_acc, load_acc, full;

	logic [7:0]          hist [M];
	logic [M-1:0][PS-1:0][7:0] cell_pat;
	logic [M-1:0][PS-1:0]      cell_eq;
	logic [PS-1:0][M-1:0][7:0] slot_pat;
	logic [PS-1:0][M-1:0]      slot_eq;
	logic [PS-1:0]       hits;
	logic [PS-1:0]       done;
	logic [LW-1:0]       slot_len [PS];
	logic [2:0]          slot_kw [PS];
	logic                slot_enc [PS];

	logic [PS-1:0] src_mask, rest, rem_next;
	logic [OB-1:0] src_end, start_v;
	logic [4:0]    src_n;
	logic [SW-1:0] low;
	logic          has, limit, out_free, emit, last_v;
	logic [63:0]   start64;

	assign in_acc   = in_valid && !in_stall;
	assign scan_acc = in_acc && (cmd == CMD_SCAN);
	assign new_acc  = in_acc && (cmd == CMD_NEW_SCAN);
	assign load_acc = in_acc && (cmd == CMD_LOAD) && (int'(pattern_slot) < PS);
	assign full     = (bytes_seen_q == '1);

	// History window: a chain of cells, newest byte at age zero.
	for (genvar a = 0; a < M; a++) begin : g_cell
		logic [7:0] nb;
		if (a == 0) begin : g_first
			assign nb = byte_value;
		end else begin : g_next
			assign nb = hist[a-1];
		end
		mpbm_cell #(.SLOTS(PS)) u_cell (
			.clk      (clk),
			.shift    (scan_acc),
			.byte_in  (nb),
			.byte_out (hist[a]),
			.pat      (cell_pat[a]),
			.eq       (cell_eq[a])
		);
		for (genvar s = 0; s < PS; s++) begin : g_x
			assign cell_pat[a][s] = slot_pat[s][a];
			assign slot_eq[s][a]  = cell_eq[a][s];
		end
	end

	for (genvar s = 0; s < PS; s++) begin : g_slot
		mpbm_slot #(
			.SLOT_ID           (s),
			.MAX_PATTERN_BYTES (M),
			.OFFSET_BITS       (OB)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld_q),
			.eq      (slot_eq[s]),
			.eval    (ev_s1),
			.clear   (new_acc),
			.end_ofs (bytes_seen_q),
			.hit     (hits[s]),
			.ld_done (done[s]),
			.pat     (slot_pat[s]),
			.len     (slot_len[s]),
			.kw      (slot_kw[s]),
			.enc     (slot_enc[s])
		);
	end

	// Drain: the hit mask of the byte under evaluation, or what is left of the last one.
	always_comb begin
		src_mask = ev_s1 ? hits : rem_q;
		src_end  = ev_s1 ? bytes_seen_q : end_q;
		src_n    = ev_s1 ? 5'd0 : n_q;
		has      = (src_mask != '0);
		limit    = (findings_q >= max_q);
		out_free = !out_valid || !out_stall;
		low      = '0;
		for (int s = PS - 1; s >= 0; s--) begin
			if (src_mask[s]) begin
				low = SW'(s);
			end
		end
		rest = src_mask;
		for (int s = 0; s < PS; s++) begin
			if (SW'(s) == low) begin
				rest[s] = 1'b0;
			end
		end
		last_v = (rest == '0) || ((17'(findings_q) + 17'd1) >= 17'(max_q))
			|| ((src_n + 5'd1) == 5'(RESULT_CAP));
		emit     = has && !limit && out_free;
		if (has && limit) begin
			rem_next = '0;
		end else if (emit) begin
			rem_next = last_v ? '0 : rest;
		end else begin
			rem_next = src_mask;
		end
		start_v = src_end - OB'(slot_len[low]);
		start64 = 64'(start_v);
	end

	assign in_stall = ld_q.busy || (rem_next != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= MAX_FINDINGS_RST;
			ld_q         <= '0;
			ev_s1        <= 1'b0;
			bytes_seen_q <= '0;
			findings_q   <= '0;
			rem_q        <= '0;
			n_q          <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_FINDINGS)) begin
				max_q <= pwdata[15:0];
			end
			if (load_acc) begin
				ld_q.busy  <= 1'b1;
				ld_q.slot  <= pattern_slot;
				ld_q.len   <= (9'(pattern_length) > 9'(M)) ? 9'(M) : 9'(pattern_length);
				ld_q.idx   <= byte_index;
				ld_q.value <= byte_value;
				ld_q.kw    <= keyword_id;
				ld_q.enc   <= encoding;
			end else if (done != '0) begin
				ld_q.busy <= 1'b0;
			end
			ev_s1 <= scan_acc && !full;
			if (new_acc) begin
				bytes_seen_q <= '0;
			end else if (scan_acc && !full) begin
				bytes_seen_q <= bytes_seen_q + OB'(1);
			end
			if (new_acc) begin
				findings_q <= '0;
			end else if (emit) begin
				findings_q <= findings_q + 16'd1;
			end
			rem_q <= rem_next;
			if (emit) begin
				n_q <= src_n + 5'd1;
			end else begin
				n_q <= src_n;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		end_q <= src_end;
		if (emit) begin
			match_slot     <= 4'(low);
			match_keyword  <= slot_kw[low];
			match_encoding <= slot_enc[low];
			start_offset   <= start64[47:0];
			last_of_run    <= last_v;
		end
	end

	assign prdata = {16'd0, max_q};
	assign pready = 1'b1;

endmodule

// File: hw/rtl/mpbm_checker.sv
// Port-level checker of the byte matcher and its bind to the top level.
`include "multi_pattern_byte_matcher_top_assert.svh"

module mpbm_checker import mpbm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  match_slot,
	input logic [47:0] start_offset,
	input logic        last_of_run,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// A stalled finding keeps its beat.
	`MPBM_AST_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(match_slot) && $stable(start_offset), "stalled finding changed")

	// Findings of one byte follow each other without a gap and in rising slot order.
	`MPBM_AST_NXT(a_run_order, out_valid && !out_stall && !last_of_run, out_valid && (match_slot > $past(match_slot)), "run of findings broken or out of slot order")

	// A write of the finding limit reads back in the next cycle.
	`MPBM_AST_NXT(a_cfg_readback, psel && penable && pwrite && (paddr[2] == REG_MAX_FINDINGS), prdata[15:0] == $past(pwdata[15:0]), "finding limit did not read back")

endmodule

bind multi_pattern_byte_matcher_top mpbm_checker u_mpbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.match_slot   (match_slot),
	.start_offset (start_offset),
	.last_of_run  (last_of_run),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);
